// ===== hdl/cbs_pkg.sv =====
// Package for the cubic Bezier sampler: widths, stage counts and shared types.
// No dependencies.
package cbs_pkg;

  localparam int COORD_W     = 24;
  localparam int N_W         = 6;
  localparam int LEN_W       = 32;
  localparam int PROD_W      = 12;
  localparam int WGT_W       = 20;
  localparam int N3_W        = 18;
  localparam int NUM_W       = 46;
  localparam int DIV_STAGES  = COORD_W;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int SUM_W       = SQ_W + 1;
  localparam int SQRT_STAGES = (SUM_W + 1) / 2;
  localparam int ROOT_W      = SUM_W + 1;
  localparam int DIST_W      = SQRT_STAGES;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [N_W-1:0]     count_t;

  typedef struct packed {
    logic first;
    logic last;
  } meta_t;

endpackage

// ===== hdl/cbs_curve_if.sv =====
// Valid/ready channel interfaces for curves in and points out.
// Depends on cbs_pkg.
interface cbs_curve_if;
  import cbs_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t ctrl1_x;
  coord_t ctrl1_y;
  coord_t ctrl2_x;
  coord_t ctrl2_y;
  coord_t end_x;
  coord_t end_y;
  count_t segment_count;

  modport source (output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                  end_x, end_y, segment_count, input ready);
  modport sink (input valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                end_x, end_y, segment_count, output ready);
endinterface

interface cbs_point_if;
  import cbs_pkg::*;
  logic               valid;
  logic               ready;
  coord_t             point_x;
  coord_t             point_y;
  logic               last_point;
  logic [LEN_W-1:0]   curve_length;

  modport source (output valid, point_x, point_y, last_point, curve_length, input ready);
  modport sink (input valid, point_x, point_y, last_point, curve_length, output ready);
endinterface

// ===== hdl/cubic_bezier_sampler.sv =====
// Cubic Bezier sampler top level: sequencer, weight and product stages,
// pipelined divider, pipelined square root and length accumulator.
// Depends on cbs_pkg and the channel interfaces in cbs_curve_if.sv.
//
// Usage:
//   curve (sink): one word per curve, control points and segment count N.
//     A count of zero is taken as one.
//   point (source): N+1 words per curve, in order; the last one carries
//     last_point and the polyline length, earlier ones a length of zero.
// Timing:
//   The sequencer issues one point per cycle, unless the output stalls, into a
//   58-stage pipeline. curve.ready is high whenever the sequencer is not
//   issuing and rst is low; a new curve is taken the cycle after the last
//   point of the previous one has been issued, so curves do not overlap.
//   The divider (one quotient bit per stage) and the square root (one root
//   bit per stage) set the depth.
// Reset:
//   rst clears the sequencer and every valid bit; the pipeline is empty.
// Stall:
//   While point.valid is high and point.ready low, the whole pipeline and
//   the sequencer hold; no word is lost or repeated.
module cubic_bezier_sampler
  import cbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  cbs_curve_if.sink           curve,
  cbs_point_if.source         point
);

  logic                adv;
  logic                busy;
  count_t              seq_i;
  count_t              seq_n;
  coord_t              seq_p [8];

  logic                a_v;
  meta_t               a_meta;
  count_t              a_u, a_i, a_n;
  logic [PROD_W-1:0]   a_uu, a_ii, a_nn;
  coord_t              a_p [8];

  logic                b_v;
  meta_t               b_meta;
  logic [WGT_W-1:0]    b_w [4];
  logic [N3_W-1:0]     b_n3;
  coord_t              b_p [8];

  logic                c_v;
  meta_t               c_meta;
  logic signed [NUM_W-1:0] c_prod [8];
  logic [N3_W-1:0]     c_n3;

  logic                d_v;
  meta_t               d_meta;
  logic [NUM_W-1:0]    d_num [2];
  logic [N3_W-1:0]     d_n3;

  logic                dv_v    [DIV_STAGES];
  meta_t               dv_meta [DIV_STAGES];
  logic [NUM_W-1:0]    dv_rem  [DIV_STAGES][2];
  logic [COORD_W-1:0]  dv_q    [DIV_STAGES][2];
  logic [N3_W-1:0]     dv_n3   [DIV_STAGES];

  coord_t              e_x, e_y;
  coord_t              prev_x, prev_y;

  logic                f_v;
  meta_t               f_meta;
  coord_t              f_x, f_y;
  logic [DIFF_W-1:0]   f_ax, f_ay;

  logic                g_v;
  meta_t               g_meta;
  coord_t              g_x, g_y;
  logic [SQ_W-1:0]     g_sx, g_sy;

  logic                h_v;
  meta_t               h_meta;
  coord_t              h_x, h_y;
  logic [SUM_W-1:0]    h_sum;

  logic                sq_v    [SQRT_STAGES];
  meta_t               sq_meta [SQRT_STAGES];
  coord_t              sq_x    [SQRT_STAGES];
  coord_t              sq_y    [SQRT_STAGES];
  logic [SUM_W-1:0]    sq_rad  [SQRT_STAGES];
  logic [ROOT_W-1:0]   sq_root [SQRT_STAGES];

  logic [LEN_W-1:0]    acc;
  logic [LEN_W-1:0]    acc_next;
  logic [LEN_W:0]      acc_sum;
  logic [DIST_W-1:0]   seg_len;

  logic                o_v;
  coord_t              o_x, o_y;
  logic                o_last;
  logic [LEN_W-1:0]    o_len;

  count_t              u_cur;
  logic signed [DIFF_W-1:0] dx, dy;

  assign adv         = !o_v || point.ready;
  assign curve.ready = !busy && !rst;
  assign u_cur       = seq_n - seq_i;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      seq_i <= '0;
      seq_n <= '0;
    end else if (curve.valid && !busy) begin
      busy  <= 1'b1;
      seq_i <= '0;
      seq_n <= (curve.segment_count == '0) ? count_t'(1) : curve.segment_count;
    end else if (busy && adv) begin
      seq_i <= seq_i + count_t'(1);
      if (seq_i == seq_n) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (curve.valid && !busy) begin
      seq_p[0] <= curve.start_x;
      seq_p[1] <= curve.start_y;
      seq_p[2] <= curve.ctrl1_x;
      seq_p[3] <= curve.ctrl1_y;
      seq_p[4] <= curve.ctrl2_x;
      seq_p[5] <= curve.ctrl2_y;
      seq_p[6] <= curve.end_x;
      seq_p[7] <= curve.end_y;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      o_v <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) dv_v[k] <= 1'b0;
      for (int k = 0; k < SQRT_STAGES; k++) sq_v[k] <= 1'b0;
    end else if (adv) begin
      a_v <= busy;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      dv_v[0] <= d_v;
      for (int k = 1; k < DIV_STAGES; k++) dv_v[k] <= dv_v[k-1];
      f_v <= dv_v[DIV_STAGES-1];
      g_v <= f_v;
      h_v <= g_v;
      sq_v[0] <= h_v;
      for (int k = 1; k < SQRT_STAGES; k++) sq_v[k] <= sq_v[k-1];
      o_v <= sq_v[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv && sq_v[SQRT_STAGES-1]) begin
      acc <= acc_next;
    end
  end

  assign e_x = coord_t'(dv_q[DIV_STAGES-1][0] ^ {1'b1, {(COORD_W-1){1'b0}}});
  assign e_y = coord_t'(dv_q[DIV_STAGES-1][1] ^ {1'b1, {(COORD_W-1){1'b0}}});
  assign dx  = DIFF_W'(e_x) - DIFF_W'(prev_x);
  assign dy  = DIFF_W'(e_y) - DIFF_W'(prev_y);

  assign seg_len  = sq_meta[SQRT_STAGES-1].first ? '0 : DIST_W'(sq_root[SQRT_STAGES-1]);
  assign acc_sum  = {1'b0, acc} + (LEN_W+1)'(seg_len);
  assign acc_next = sq_meta[SQRT_STAGES-1].first ? '0 :
                    (acc_sum[LEN_W] ? {LEN_W{1'b1}} : acc_sum[LEN_W-1:0]);

  // datapath
  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] trial;
    logic [ROOT_W-1:0] rb;
    logic [NUM_W-1:0]  rin;
    logic [SUM_W-1:0]  vin;
    logic [ROOT_W-1:0] root_in;
    if (adv) begin
      a_meta <= '{first: (seq_i == '0), last: (seq_i == seq_n)};
      a_u    <= u_cur;
      a_i    <= seq_i;
      a_n    <= seq_n;
      a_uu   <= PROD_W'(u_cur) * PROD_W'(u_cur);
      a_ii   <= PROD_W'(seq_i) * PROD_W'(seq_i);
      a_nn   <= PROD_W'(seq_n) * PROD_W'(seq_n);
      a_p    <= seq_p;

      b_meta <= a_meta;
      b_w[0] <= WGT_W'(a_uu) * WGT_W'(a_u);
      b_w[1] <= WGT_W'(a_uu) * WGT_W'(a_i) * WGT_W'(3);
      b_w[2] <= WGT_W'(a_ii) * WGT_W'(a_u) * WGT_W'(3);
      b_w[3] <= WGT_W'(a_ii) * WGT_W'(a_i);
      b_n3   <= N3_W'(a_nn) * N3_W'(a_n);
      b_p    <= a_p;

      c_meta <= b_meta;
      c_n3   <= b_n3;
      for (int k = 0; k < 8; k++) begin
        c_prod[k] <= NUM_W'($signed({1'b0, b_w[k/2]})) * NUM_W'(b_p[k]);
      end

      d_meta <= c_meta;
      d_n3   <= c_n3;
      for (int c = 0; c < 2; c++) begin
        d_num[c] <= NUM_W'(c_prod[c] + c_prod[c+2] + c_prod[c+4] + c_prod[c+6])
                    + NUM_W'(c_n3 >> 1) + (NUM_W'(c_n3) << (COORD_W-1));
      end

      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_meta[k] <= (k == 0) ? d_meta : dv_meta[k-1];
        dv_n3[k]   <= (k == 0) ? d_n3 : dv_n3[k-1];
        for (int c = 0; c < 2; c++) begin
          rin   = (k == 0) ? d_num[c] : dv_rem[k-1][c];
          trial = NUM_W'((k == 0) ? d_n3 : dv_n3[k-1]) << (DIV_STAGES-1-k);
          if (rin >= trial) begin
            dv_rem[k][c] <= rin - trial;
          end else begin
            dv_rem[k][c] <= rin;
          end
          dv_q[k][c] <= {((k == 0) ? {(COORD_W-1){1'b0}} : dv_q[k-1][c][COORD_W-2:0]),
                         rin >= trial};
        end
      end

      if (dv_v[DIV_STAGES-1]) begin
        prev_x <= e_x;
        prev_y <= e_y;
      end
      f_meta <= dv_meta[DIV_STAGES-1];
      f_x    <= e_x;
      f_y    <= e_y;
      f_ax   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      f_ay   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

      g_meta <= f_meta;
      g_x    <= f_x;
      g_y    <= f_y;
      g_sx   <= SQ_W'(f_ax) * SQ_W'(f_ax);
      g_sy   <= SQ_W'(f_ay) * SQ_W'(f_ay);

      h_meta <= g_meta;
      h_x    <= g_x;
      h_y    <= g_y;
      h_sum  <= SUM_W'(g_sx) + SUM_W'(g_sy);

      for (int k = 0; k < SQRT_STAGES; k++) begin
        sq_meta[k] <= (k == 0) ? h_meta : sq_meta[k-1];
        sq_x[k]    <= (k == 0) ? h_x : sq_x[k-1];
        sq_y[k]    <= (k == 0) ? h_y : sq_y[k-1];
        vin        = (k == 0) ? h_sum : sq_rad[k-1];
        root_in    = (k == 0) ? '0 : sq_root[k-1];
        rb         = ROOT_W'(1) << (2 * (SQRT_STAGES-1-k));
        if (ROOT_W'(vin) >= root_in + rb) begin
          sq_rad[k]  <= SUM_W'(ROOT_W'(vin) - root_in - rb);
          sq_root[k] <= (root_in >> 1) + rb;
        end else begin
          sq_rad[k]  <= vin;
          sq_root[k] <= root_in >> 1;
        end
      end

      o_x    <= sq_x[SQRT_STAGES-1];
      o_y    <= sq_y[SQRT_STAGES-1];
      o_last <= sq_meta[SQRT_STAGES-1].last;
      o_len  <= sq_meta[SQRT_STAGES-1].last ? acc_next : '0;
    end
  end

  assign point.valid        = o_v;
  assign point.point_x      = o_x;
  assign point.point_y      = o_y;
  assign point.last_point   = o_last;
  assign point.curve_length = o_len;

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> seq_i <= seq_n)
    else $error("sequencer index past segment count");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    busy && !adv |=> $stable(seq_i))
    else $error("sequencer advanced during stall");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    o_v && !o_last |-> o_len == '0)
    else $error("length on a non-final point");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy && adv && seq_i == seq_n |=> !busy)
    else $error("sequencer did not finish after last point");

endmodule

// ===== test/cubic_bezier_sampler_tb.sv =====
// Self-checking testbench for cubic_bezier_sampler: a directed table, then random curves.
// Each curve word is predicted into a queue of expected points and compared on the point side.
// Depends on cbs_pkg, cbs_curve_if.sv and the RTL.
module cubic_bezier_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbs_pkg::*;

  localparam coord_t CMAX = 24'sh7FFFFF;
  localparam coord_t CMIN = -24'sh800000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic last;
    logic [LEN_W-1:0] len;
  } point_t;

  typedef struct {
    coord_t c [8];
    count_t n;
    logic checked;
    coord_t ex;
    coord_t ey;
  } curve_row_t;

  logic clk;
  logic rst;
  cbs_curve_if curve ();
  cbs_point_if point ();

  cubic_bezier_sampler dut (.clk(clk), .rst(rst), .curve(curve), .point(point));

  point_t points_due [$];
  int errors;
  bit quiet;
  curve_row_t rows [$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic longint sample_coord(longint p0, longint c1, longint c2, longint p3,
                                          longint i, longint n);
    longint u, n3, num, q;
    u = n - i;
    n3 = n * n * n;
    num = u * u * u * p0 + 3 * u * u * i * c1 + 3 * u * i * i * c2 + i * i * i * p3;
    q = num + (n3 >>> 1);
    if (q >= 0) return q / n3;
    return -((-q + n3 - 1) / n3);
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint hop(longint x0, longint y0, longint x1, longint y1);
    longint dx, dy;
    dx = x1 - x0;
    dy = y1 - y0;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return int_root(dx * dx + dy * dy);
  endfunction

  task automatic predict_points(input curve_row_t r);
    longint n, i, x, y, px, py, total;
    point_t p;
    n = longint'(r.n);
    if (n < 1) n = 1;
    total = 0;
    px = 0;
    py = 0;
    for (i = 0; i < n; i++) begin
      x = sample_coord(longint'(r.c[0]), longint'(r.c[2]), longint'(r.c[4]),
                       longint'(r.c[6]), i, n);
      y = sample_coord(longint'(r.c[1]), longint'(r.c[3]), longint'(r.c[5]),
                       longint'(r.c[7]), i, n);
      if (i != 0) total += hop(px, py, x, y);
      if (total > 64'hFFFFFFFF) total = 64'hFFFFFFFF;
      px = x;
      py = y;
      p.x = coord_t'(x);
      p.y = coord_t'(y);
      p.last = 0;
      p.len = 0;
      points_due = {points_due, p};
    end
    total += hop(px, py, longint'(r.c[6]), longint'(r.c[7]));
    if (total > 64'hFFFFFFFF) total = 64'hFFFFFFFF;
    p.x = r.c[6];
    p.y = r.c[7];
    p.last = 1;
    p.len = LEN_W'(total);
    points_due = {points_due, p};
  endtask

  task automatic send_curve(input curve_row_t r);
    while (!quiet && $urandom_range(99) < 10) begin
      curve.valid <= 0;
      @(negedge clk);
    end
    predict_points(r);
    if (r.checked) begin
      if (points_due[$].x != r.ex)
        report("table end x", longint'(points_due[$].x), longint'(r.ex));
      if (points_due[$].y != r.ey)
        report("table end y", longint'(points_due[$].y), longint'(r.ey));
    end
    curve.valid <= 1;
    curve.start_x <= r.c[0];
    curve.start_y <= r.c[1];
    curve.ctrl1_x <= r.c[2];
    curve.ctrl1_y <= r.c[3];
    curve.ctrl2_x <= r.c[4];
    curve.ctrl2_y <= r.c[5];
    curve.end_x <= r.c[6];
    curve.end_y <= r.c[7];
    curve.segment_count <= r.n;
    do @(posedge clk); while (!curve.ready);
    @(negedge clk);
  endtask

  function automatic curve_row_t make_row(coord_t v, count_t n);
    curve_row_t r;
    foreach (r.c[k]) r.c[k] = v;
    r.n = n;
    r.checked = 1;
    r.ex = v;
    r.ey = v;
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(2000) - 1000);
      2: return $urandom_range(1) ? CMAX : CMIN;
      default: return coord_t'($urandom_range(65535) - 32768);
    endcase
  endfunction

  always @(posedge clk) begin
    point_t e;
    if (!rst && point.valid && point.ready) begin
      if (points_due.size() == 0) begin
        report("unexpected point", longint'(point.point_x), 0);
      end else begin
        e = points_due.pop_front();
        if (point.point_x != e.x)
          report("point_x", longint'(point.point_x), longint'(e.x));
        if (point.point_y != e.y)
          report("point_y", longint'(point.point_y), longint'(e.y));
        if (point.last_point != e.last)
          report("last_point", longint'(point.last_point), longint'(e.last));
        if (point.curve_length != e.len)
          report("curve_length", longint'(point.curve_length), longint'(e.len));
      end
    end
  end

  always @(negedge clk) begin
    point.ready <= quiet || rst || ($urandom_range(99) >= 10);
  end

  initial begin
    curve_row_t r;
    int mode, cnt;
    errors = 0;
    quiet = 0;
    rst = 1;
    curve.valid = 0;
    curve.start_x = 0;
    curve.start_y = 0;
    curve.ctrl1_x = 0;
    curve.ctrl1_y = 0;
    curve.ctrl2_x = 0;
    curve.ctrl2_y = 0;
    curve.end_x = 0;
    curve.end_y = 0;
    curve.segment_count = 0;
    point.ready = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    rows = {rows, make_row('0, '0)};
    rows = {rows, make_row(CMAX, count_t'(1))};
    rows = {rows, make_row(CMIN, count_t'(63))};
    rows = {rows, make_row(coord_t'(-1), count_t'(2))};
    r = make_row(CMIN, count_t'(63));
    r.c[6] = CMAX;
    r.c[7] = CMAX;
    r.c[1] = CMAX;
    r.c[2] = CMAX;
    r.c[5] = CMIN;
    r.ex = CMAX;
    r.ey = CMAX;
    rows = {rows, r};
    r = make_row(CMAX, count_t'(3));
    r.c[0] = CMIN;
    r.c[3] = CMIN;
    r.c[6] = CMIN;
    r.ex = CMIN;
    rows = {rows, r};
    for (int k = 0; k < 10; k++) begin
      for (int j = 0; j < 8; j++) r.c[j] = rand_coord(k % 4);
      r.n = count_t'(k * 7);
      r.checked = 0;
      rows = {rows, r};
    end
    foreach (rows[k]) send_curve(rows[k]);

    for (int k = 0; k < 200; k++) begin
      quiet = (k >= 80 && k < 110);
      mode = $urandom_range(3);
      for (int j = 0; j < 8; j++) r.c[j] = rand_coord(mode);
      cnt = $urandom_range(99);
      r.n = cnt < 70 ? count_t'($urandom_range(8)) : count_t'($urandom);
      r.checked = 0;
      send_curve(r);
    end
    curve.valid <= 0;

    while (points_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
